/* hdl/tcce_pkg.sv */
// Shared types and constants for the text console character engine.
// Used by the channel interfaces and every module of the block; no dependencies.
package tcce_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int STORE_DEPTH    = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int MEM_AW         = $clog2(STORE_DEPTH);

    // A row (5 bits) times a width (7 bits) plus a column (8 bits) stays below 2^13.
    localparam int IDX_MIN_W = 13;
    localparam int CIDX_W    = ($clog2(STORE_DEPTH + 1) > IDX_MIN_W) ?
                               $clog2(STORE_DEPTH + 1) : IDX_MIN_W;
    localparam logic [CIDX_W-1:0] DEPTH_IDX = CIDX_W'(STORE_DEPTH);

    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] TAB_STEP = 8'd8;
    localparam logic [7:0] TAB_MASK = ~8'(8 - 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [6:0] RST_WINDOW_LEFT     = 7'd0;
    localparam logic [4:0] RST_WINDOW_TOP      = 5'd0;
    localparam logic [6:0] RST_WINDOW_WIDTH    = 7'd80;
    localparam logic [4:0] RST_WINDOW_HEIGHT   = 5'd25;
    localparam logic [6:0] RST_BACKSPACE_FLOOR = 7'd0;
    localparam logic [3:0] RST_BACK_COLOR      = 4'd0;
    localparam logic [3:0] RST_TEXT_COLOR      = 4'd1;

    localparam int CMD_Q_DEPTH = 2;  // power of two, pointers wrap freely
    localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);

    typedef enum logic [2:0] {
        REG_WINDOW_LEFT     = 3'd0,
        REG_WINDOW_TOP      = 3'd1,
        REG_WINDOW_WIDTH    = 3'd2,
        REG_WINDOW_HEIGHT   = 3'd3,
        REG_BACKSPACE_FLOOR = 3'd4,
        REG_BACK_COLOR      = 3'd5,
        REG_TEXT_COLOR      = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        KIND_PRINT,
        KIND_BS,
        KIND_LF,
        KIND_TAB,
        KIND_CR,
        KIND_READ
    } t_cmd_kind;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCROLL_SETUP,
        BK_SCROLL,
        BK_FINISH
    } t_back_state;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_cmd;

    typedef struct packed {
        logic [6:0] window_left;
        logic [4:0] window_top;
        logic [6:0] window_width;
        logic [4:0] window_height;
        logic [6:0] backspace_floor;
        logic [3:0] back_color;
        logic [3:0] text_color;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic clear_busy;
    } t_back_status;

endpackage

/* hdl/tcce_if.sv */
// Valid/ready channel interfaces of the text console character engine:
// command input, result output and configuration write. Depends on tcce_pkg.
interface tcce_cmd_if;
    import tcce_pkg::*;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, output op, output char_code, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input op, input char_code, input read_row,
                    input read_col, output ready);
endinterface

interface tcce_res_if;
    import tcce_pkg::*;
    logic        valid;
    logic        ready;
    logic [15:0] cursor_location;
    logic [7:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] read_cell;

    modport source (output valid, output cursor_location, output cursor_col,
                    output cursor_row, output read_cell, input ready);
    modport sink   (input valid, input cursor_location, input cursor_col,
                    input cursor_row, input read_cell, output ready);
endinterface

interface tcce_cfg_if;
    import tcce_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/tcce_cmd_q.sv */
// Short command queue between the front and the back of the console engine.
// Depends on tcce_pkg for the command type and the queue depth.
module tcce_cmd_q (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tcce_pkg::t_cmd       i_push_cmd,
    input  logic                 i_pop,
    output tcce_pkg::t_cmd       o_head,
    output tcce_pkg::t_q_status  o_status
);
    import tcce_pkg::*;

    t_cmd                r_slots [CMD_Q_DEPTH];
    logic [CMD_Q_AW-1:0] r_wr_ptr;
    logic [CMD_Q_AW-1:0] r_rd_ptr;
    logic [CMD_Q_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + CMD_Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + CMD_Q_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (CMD_Q_AW + 1)'(1);
                2'b01:   r_count <= r_count - (CMD_Q_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_cmd;
        end
    end

    assign o_head         = r_slots[r_rd_ptr];
    assign o_status.full  = (r_count == (CMD_Q_AW + 1)'(CMD_Q_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

/* hdl/tcce_front.sv */
// Front of the console engine: takes input items and sorts each into a command kind, a read or by its byte.
// Depends on tcce_pkg and the command channel interface.
module tcce_front (
    tcce_cmd_if.sink                 i_cmd,
    input  tcce_pkg::t_q_status      i_q_status,
    input  tcce_pkg::t_back_status   i_back_status,
    output logic                     o_push,
    output tcce_pkg::t_cmd           o_push_cmd
);
    import tcce_pkg::*;

    // Items wait while the queue is full or the store is being cleared after reset.
    assign i_cmd.ready = !i_q_status.full && !i_back_status.clear_busy;
    assign o_push      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        o_push_cmd.char_code = i_cmd.char_code;
        o_push_cmd.read_row  = i_cmd.read_row;
        o_push_cmd.read_col  = i_cmd.read_col;
        if (i_cmd.op) begin
            o_push_cmd.kind = KIND_READ;
        end else begin
            unique case (i_cmd.char_code)
                CH_BS:   o_push_cmd.kind = KIND_BS;
                CH_LF:   o_push_cmd.kind = KIND_LF;
                CH_TAB:  o_push_cmd.kind = KIND_TAB;
                CH_CR:   o_push_cmd.kind = KIND_CR;
                default: o_push_cmd.kind = KIND_PRINT;
            endcase
        end
    end

endmodule

/* hdl/tcce_back.sv */
// Back of the console engine: cursor, cell store, scroll sequencer and result register.
// Depends on tcce_pkg and the result channel interface.
module tcce_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tcce_pkg::t_cfg           i_cfg,
    input  tcce_pkg::t_q_status      i_q_status,
    input  tcce_pkg::t_cmd           i_head,
    output logic                     o_pop,
    output tcce_pkg::t_back_status   o_status,
    tcce_res_if.source               o_res
);
    import tcce_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [15:0]       r_cells [STORE_DEPTH];
    logic [15:0]       r_rd_data;

    logic [7:0]        r_col;
    logic [4:0]        r_row;
    logic [CIDX_W-1:0] r_idx;
    logic [CIDX_W-1:0] r_limit;
    logic              r_wb_valid;
    logic [CIDX_W-1:0] r_wb_idx;
    logic              r_wb_blank;
    logic              r_wb_src_ok;
    logic              r_is_read;
    logic              r_rd_ok;

    logic              r_out_valid;
    logic [15:0]       r_out_loc;
    logic [7:0]        r_out_col;
    logic [4:0]        r_out_row;
    logic [15:0]       r_out_cell;

    logic              take;
    logic [7:0]        attr;
    logic [15:0]       blank;
    logic [4:0]        h_used;

    logic              wrap;
    logic [7:0]        col0;
    logic [4:0]        row0;
    logic [7:0]        col_dec;
    logic [7:0]        col_n;
    logic [4:0]        row_n;
    logic [4:0]        row_a;
    logic [7:0]        col_a;
    logic              exec_wr;
    logic [15:0]       exec_data;
    logic [CIDX_W-1:0] exec_idx;
    logic              exec_idx_ok;
    logic              need_scroll;

    logic [CIDX_W-1:0] total;
    logic [CIDX_W-1:0] src_idx;
    logic              issue;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [MEM_AW-1:0] mem_raddr;
    logic [15:0]       mem_wdata;

    logic [15:0]       loc_rows;
    logic [15:0]       loc;

    assign take   = r_out_valid && o_res.ready;
    assign attr   = {i_cfg.back_color, i_cfg.text_color};
    assign blank  = {attr, CH_BLANK};
    assign h_used = (i_cfg.window_height == 5'd0) ? 5'd1 : i_cfg.window_height;

    // Cursor update and cell write for the command at the head of the queue.
    always_comb begin
        wrap      = (r_col >= {1'b0, i_cfg.window_width});
        col0      = wrap ? 8'd0 : r_col;
        row0      = wrap ? (r_row + 5'd1) : r_row;
        col_dec   = col0 - 8'd1;
        col_n     = r_col;
        row_n     = r_row;
        row_a     = row0;
        col_a     = col0;
        exec_wr   = 1'b0;
        exec_data = {attr, i_head.char_code};
        unique case (i_head.kind)
            KIND_BS: begin
                row_n   = row0;
                exec_wr = 1'b1;
                if (col0 != 8'd0) begin
                    col_n     = (col_dec < {1'b0, i_cfg.backspace_floor}) ?
                                {1'b0, i_cfg.backspace_floor} : col_dec;
                    col_a     = col_n;
                    exec_data = blank;
                end else begin
                    // At the left edge the byte is drawn as a glyph.
                    col_n = col0 + 8'd1;
                end
            end
            KIND_LF: begin
                col_n = 8'd0;
                row_n = row0 + 5'd1;
            end
            KIND_TAB: begin
                col_n = (col0 + TAB_STEP) & TAB_MASK;
                row_n = row0;
            end
            KIND_CR: begin
                col_n = 8'd0;
                row_n = row0;
            end
            KIND_READ: begin
                row_a = i_head.read_row;
                col_a = {1'b0, i_head.read_col};
            end
            KIND_PRINT: begin
                exec_wr = 1'b1;
                col_n   = col0 + 8'd1;
                row_n   = row0;
            end
            default: begin
                col_n = r_col;
            end
        endcase
        exec_idx    = CIDX_W'(row_a) * CIDX_W'(i_cfg.window_width) + CIDX_W'(col_a);
        exec_idx_ok = (exec_idx < DEPTH_IDX);
        need_scroll = (i_head.kind != KIND_READ) && (row_n >= h_used);
    end

    // Scroll walks the window's cells of the store once: copy from one row below, then blank the last row.
    assign total   = r_limit + CIDX_W'(i_cfg.window_width);
    assign src_idx = r_idx + CIDX_W'(i_cfg.window_width);
    assign issue   = (r_idx < total);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: begin
                if (r_idx == DEPTH_IDX - CIDX_W'(1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (o_pop) begin
                    n_state = need_scroll ? BK_SCROLL_SETUP : BK_FINISH;
                end
            end
            BK_SCROLL_SETUP: n_state = BK_SCROLL;
            BK_SCROLL: begin
                if (!issue && !r_wb_valid) begin
                    n_state = BK_FINISH;
                end
            end
            BK_FINISH: n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == BK_IDLE) && !i_q_status.empty && (!r_out_valid || o_res.ready);
        o_status.clear_busy = (r_state == BK_CLEAR);
        mem_we    = 1'b0;
        mem_waddr = r_idx[MEM_AW-1:0];
        mem_wdata = 16'h0000;
        priority if (r_state == BK_CLEAR) begin
            mem_we = 1'b1;
        end else if (o_pop && exec_wr && exec_idx_ok) begin
            mem_we    = 1'b1;
            mem_waddr = exec_idx[MEM_AW-1:0];
            mem_wdata = exec_data;
        end else if (r_wb_valid && (r_wb_idx < DEPTH_IDX)) begin
            mem_we    = 1'b1;
            mem_waddr = r_wb_idx[MEM_AW-1:0];
            mem_wdata = r_wb_blank ? blank : (r_wb_src_ok ? r_rd_data : 16'h0000);
        end else begin
            mem_we = 1'b0;
        end
        mem_raddr = (r_state == BK_SCROLL) ? src_idx[MEM_AW-1:0] : exec_idx[MEM_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cells[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_cells[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_idx       <= '0;
            r_col       <= 8'd0;
            r_row       <= 5'd0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                BK_CLEAR: r_idx <= r_idx + CIDX_W'(1);
                BK_IDLE: begin
                    if (o_pop) begin
                        r_col <= col_n;
                        r_row <= row_n;
                    end
                end
                BK_SCROLL_SETUP: begin
                    r_idx <= '0;
                    r_row <= h_used - 5'd1;
                end
                BK_SCROLL: begin
                    if (issue) begin
                        r_idx <= r_idx + CIDX_W'(1);
                    end
                end
                default: r_idx <= r_idx;
            endcase
            r_wb_valid <= (r_state == BK_SCROLL) && issue;
            if (r_state == BK_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign loc_rows = (16'(i_cfg.window_top) + 16'(r_row)) * 16'(SCREEN_COLUMNS);
    assign loc      = loc_rows + 16'(i_cfg.window_left) + 16'(r_col);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_is_read <= (i_head.kind == KIND_READ);
            r_rd_ok   <= exec_idx_ok;
        end
        if (r_state == BK_SCROLL_SETUP) begin
            r_limit <= CIDX_W'(h_used - 5'd1) * CIDX_W'(i_cfg.window_width);
        end
        r_wb_idx    <= r_idx;
        r_wb_blank  <= (r_idx >= r_limit);
        r_wb_src_ok <= (src_idx < DEPTH_IDX);
        if (r_state == BK_FINISH) begin
            r_out_loc  <= loc;
            r_out_col  <= r_col;
            r_out_row  <= r_row;
            r_out_cell <= (r_is_read && r_rd_ok) ? r_rd_data : 16'h0000;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.cursor_location = r_out_loc;
    assign o_res.cursor_col      = r_out_col;
    assign o_res.cursor_row      = r_out_row;
    assign o_res.read_cell       = r_out_cell;

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CLEAR) |-> !r_out_valid)
        else $error("result valid during the clearing pass");

    a_wb_only_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> (r_state == BK_SCROLL))
        else $error("scroll write-back outside the scroll sequence");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_FINISH) |-> !r_out_valid)
        else $error("result register still occupied when a result is loaded");

    a_read_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == BK_IDLE) && o_pop && (i_head.kind == KIND_READ))
        |=> (r_state == BK_FINISH))
        else $error("cell read did not complete in the following cycle");

endmodule

/* hdl/text_console_char_engine_top.sv */
// Top level of the text console character engine: configuration registers and
// the front, command queue and back. Depends on tcce_pkg and the channel interfaces.
//
// Usage:
//   i_cmd carries one item per handshake: op 0 puts char_code at the cursor
//   (TAB, LF and CR only move the cursor; away from the left edge, BS steps back
//   and blanks a cell), op 1 reads the cell at (read_row, read_col) of the
//   window. Every item gives exactly one result on o_res: cursor location,
//   column, row and the cell read (zero for a put). i_cfg writes register 'index'
//   with 'data'; it is always ready and is to be used only while the block is
//   idle, though the block itself does not enforce this. Once its command leaves
//   the queue, a put or a read updates the cursor and accesses the cell store,
//   then loads the result register in the FINISH state. A command that moves the
//   cursor past the last window row scrolls the store through its single read
//   and write port, one cell a cycle, before the result is loaded.
//   A two-entry queue decouples the input from the back, so items are taken
//   while a result waits on a stalled receiver; when the result register is
//   full and not taken, the back holds and the queue fills, then i_cmd.ready
//   drops.
//   After reset the cell store is zeroed one cell a cycle, with i_cmd.ready low.
//   Registers return to their reset values and the cursor to row 0, column 0.
module text_console_char_engine_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcce_cmd_if.sink   i_cmd,
    tcce_res_if.source o_res,
    tcce_cfg_if.sink   i_cfg
);
    import tcce_pkg::*;

    t_cfg         r_cfg;
    t_q_status    q_status;
    t_back_status back_status;
    t_cmd         push_cmd;
    t_cmd         head_cmd;
    logic         push;
    logic         pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_left     <= RST_WINDOW_LEFT;
            r_cfg.window_top      <= RST_WINDOW_TOP;
            r_cfg.window_width    <= RST_WINDOW_WIDTH;
            r_cfg.window_height   <= RST_WINDOW_HEIGHT;
            r_cfg.backspace_floor <= RST_BACKSPACE_FLOOR;
            r_cfg.back_color      <= RST_BACK_COLOR;
            r_cfg.text_color      <= RST_TEXT_COLOR;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_WINDOW_LEFT:     r_cfg.window_left     <= i_cfg.data[6:0];
                REG_WINDOW_TOP:      r_cfg.window_top      <= i_cfg.data[4:0];
                REG_WINDOW_WIDTH:    r_cfg.window_width    <= i_cfg.data[6:0];
                REG_WINDOW_HEIGHT:   r_cfg.window_height   <= i_cfg.data[4:0];
                REG_BACKSPACE_FLOOR: r_cfg.backspace_floor <= i_cfg.data[6:0];
                REG_BACK_COLOR:      r_cfg.back_color      <= i_cfg.data[3:0];
                REG_TEXT_COLOR:      r_cfg.text_color      <= i_cfg.data[3:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    tcce_front u_front (
        .i_cmd         (i_cmd),
        .i_q_status    (q_status),
        .i_back_status (back_status),
        .o_push        (push),
        .o_push_cmd    (push_cmd)
    );

    tcce_cmd_q u_cmd_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head_cmd),
        .o_status   (q_status)
    );

    tcce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_head     (head_cmd),
        .o_pop      (pop),
        .o_status   (back_status),
        .o_res      (o_res)
    );

endmodule
